[design/bar_pkg.sv]
// ----------------------------------------------------------------------------
// bar_pkg
// Shared types and constants for the button auto-repeat unit.
// ----------------------------------------------------------------------------
package bar_pkg;

  localparam int unsigned ButtonWidth     = 32;
  localparam int unsigned CfgWidth        = 8;
  localparam int unsigned CfgIdxWidth     = 2;
  localparam int unsigned DefButtonCount  = 32;
  localparam int unsigned DefCounterBits  = 8;

  localparam logic [CfgWidth-1:0] StepReset      = 8'd1;
  localparam logic [CfgWidth-1:0] ThresholdReset = 8'd255;
  localparam logic [CfgWidth-1:0] ReloadReset    = 8'd0;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_STEP      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_RELOAD    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ButtonWidth-1:0] buttons_now;
    logic                   defer_flag;
  } bar_in_t;

  typedef struct packed {
    logic [ButtonWidth-1:0] held_mask;
    logic [ButtonWidth-1:0] pressed_mask;
    logic [ButtonWidth-1:0] repeat_mask;
  } bar_out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] step;
    logic [CfgWidth-1:0] threshold;
    logic [CfgWidth-1:0] reload;
  } bar_cfg_t;

endpackage

[design/bar_lane.sv]
// ----------------------------------------------------------------------------
// bar_lane
// One button lane: hold counter, threshold compare, repeat pulse.
// ----------------------------------------------------------------------------
module bar_lane import bar_pkg::*; #(
  parameter int unsigned COUNTER_BITS = DefCounterBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic     held_i,
  input  logic     pressed_i,
  input  bar_cfg_t cfg_i,
  output logic     pulse_o
);

  // compare at whichever is wider: the counter or the 8-bit threshold
  localparam int unsigned CmpW = (COUNTER_BITS > CfgWidth) ? COUNTER_BITS : CfgWidth;

  logic [COUNTER_BITS-1:0] ctr_q, ctr_d, sum;
  logic                    fire;

  always_comb begin
    sum     = ctr_q + COUNTER_BITS'(cfg_i.step);
    fire    = CmpW'(sum) >= CmpW'(cfg_i.threshold);
    pulse_o = held_i & (pressed_i | fire);
    if (!held_i) begin
      ctr_d = '0;
    end else if (fire) begin
      ctr_d = COUNTER_BITS'(cfg_i.reload);
    end else begin
      ctr_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (accept_i) begin
      ctr_q <= ctr_d;
    end
  end

endmodule

[design/bar_merge.sv]
// ----------------------------------------------------------------------------
// bar_merge
// Merges lane pulses with the deferred pending masks; output register.
// ----------------------------------------------------------------------------
module bar_merge import bar_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   defer_i,
  input  logic [ButtonWidth-1:0] held_i,
  input  logic [ButtonWidth-1:0] pressed_i,
  input  logic [ButtonWidth-1:0] pulses_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output bar_out_t               out_data_o,
  output logic                   in_ready_o
);

  logic [ButtonWidth-1:0] pend_press_q, pend_press_d;
  logic [ButtonWidth-1:0] pend_rep_q, pend_rep_d;
  logic                   valid_q, valid_d;
  bar_out_t               data_q, data_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d.held_mask = held_i;
    if (defer_i) begin
      pend_press_d        = pend_press_q | pressed_i;
      pend_rep_d          = pend_rep_q | pulses_i;
      data_d.pressed_mask = pressed_i;
      data_d.repeat_mask  = pulses_i;
    end else begin
      // flush: pending pulses ride out with this transfer
      pend_press_d        = '0;
      pend_rep_d          = '0;
      data_d.pressed_mask = pressed_i | pend_press_q;
      data_d.repeat_mask  = pulses_i | pend_rep_q;
    end
    valid_d = accept_i || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_press_q <= '0;
      pend_rep_q   <= '0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept_i) begin
        pend_press_q <= pend_press_d;
        pend_rep_q   <= pend_rep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      data_q <= data_d;
    end
  end

endmodule

[design/button_auto_repeat_unit.sv]
// ----------------------------------------------------------------------------
// button_auto_repeat_unit
// Typematic auto-repeat over a word of buttons, one counter lane per button.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_ready_o | bar_in_t  (buttons, defer)
//   out     | output    | out_valid_o/out_ready_i | bar_out_t (held/pressed/repeat)
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One poll per cycle while the output is not stalled; a result appears in the
// cycle after its transfer in, as the lane add-compare feeds the output register.
// in_ready_o stays high while the output register is empty or being drained.
// Reset clears counters, previous word and pending masks; no clearing pass.
// A stalled output holds its payload and blocks only the next transfer in.
module button_auto_repeat_unit import bar_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = DefButtonCount,
  parameter int unsigned COUNTER_BITS = DefCounterBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bar_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bar_out_t               out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i
);

  localparam logic [ButtonWidth-1:0] LaneMask =
    ButtonWidth'((64'd1 << BUTTON_COUNT) - 64'd1);

  bar_cfg_t               cfg_q;
  logic [ButtonWidth-1:0] prev_q;
  logic [ButtonWidth-1:0] now_w, pressed_w, pulses_w;
  logic                   accept;

  assign accept    = in_valid_i && in_ready_o;
  assign now_w     = in_data_i.buttons_now & LaneMask;
  assign pressed_w = now_w & ~prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step      <= StepReset;
      cfg_q.threshold <= ThresholdReset;
      cfg_q.reload    <= ReloadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP:      cfg_q.step      <= cfg_wdata_i;
        REG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i;
        REG_RELOAD:    cfg_q.reload    <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= now_w;
    end
  end

  for (genvar g = 0; g < ButtonWidth; g++) begin : g_lane
    if (g < BUTTON_COUNT) begin : g_used
      bar_lane #(
        .COUNTER_BITS(COUNTER_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .accept_i (accept),
        .held_i   (now_w[g]),
        .pressed_i(pressed_w[g]),
        .cfg_i    (cfg_q),
        .pulse_o  (pulses_w[g])
      );
    end else begin : g_unused
      assign pulses_w[g] = 1'b0;
    end
  end

  bar_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .defer_i    (in_data_i.defer_flag),
    .held_i     (now_w),
    .pressed_i  (pressed_w),
    .pulses_i   (pulses_w),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .in_ready_o (in_ready_o)
  );

endmodule

[design/bar_chk.sv]
// ----------------------------------------------------------------------------
// bar_chk
// Port-level checks for the button auto-repeat unit, bound to the top level.
// ----------------------------------------------------------------------------
module bar_chk import bar_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input bar_out_t               out_data_o
);

  // stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // every transfer in shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after transfer in");

  // a press always fires a repeat pulse, pending or not
  a_press_in_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pressed_mask & ~out_data_o.repeat_mask) == '0)
    else $error("press without repeat pulse");

endmodule

bind button_auto_repeat_unit bar_chk u_bar_chk (.*);

[tb/button_repeat_checker.sv]
// ----------------------------------------------------------------------------
// button_repeat_checker
// Watches the poll, result and register ports of the auto-repeat unit. Keeps
// its own copy of the lane counters, pending masks and registers, predicts
// the masks for every poll transfer and compares each result transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
module button_repeat_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  bar_pkg::bar_in_t                in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  bar_pkg::bar_out_t               out_data_i,
  input  logic                            cfg_we_i,
  input  logic [bar_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [bar_pkg::CfgWidth-1:0]    cfg_wdata_i,
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bar_pkg::*;

  localparam int unsigned CtrBits   = DefCounterBits;
  localparam int          PrintCap  = 60;

  // register copies
  logic [CfgWidth-1:0]    rep_step;
  logic [CfgWidth-1:0]    rep_threshold;
  logic [CfgWidth-1:0]    rep_reload;

  // lane state
  logic [ButtonWidth-1:0] last_word;
  logic [CtrBits-1:0]     lane_count [ButtonWidth];
  logic [ButtonWidth-1:0] deferred_presses;
  logic [ButtonWidth-1:0] deferred_repeats;

  bar_out_t               expected_masks [$];

  initial fail_count = 0;

  task automatic report_fail(input string msg);
    if (fail_count < PrintCap) begin
      $display("%0t ERROR %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic bar_out_t predict_poll(input bar_in_t poll);
    logic [ButtonWidth-1:0] fresh;
    logic [ButtonWidth-1:0] pulses;
    logic [CtrBits-1:0]     cnt;
    bar_out_t               res;
    fresh  = poll.buttons_now & ~last_word;
    pulses = '0;
    last_word = poll.buttons_now;
    for (int lane = 0; lane < ButtonWidth; lane++) begin
      if (poll.buttons_now[lane]) begin
        cnt = lane_count[lane] + rep_step[CtrBits-1:0];   // wraps at counter width
        if (fresh[lane]) pulses[lane] = 1'b1;
        if (cnt >= rep_threshold) begin
          cnt = rep_reload[CtrBits-1:0];
          pulses[lane] = 1'b1;
        end
        lane_count[lane] = cnt;
      end else begin
        lane_count[lane] = '0;
      end
    end
    if (poll.defer_flag) begin
      deferred_repeats |= pulses;
      deferred_presses |= fresh;
    end else begin
      fresh  |= deferred_presses;
      pulses |= deferred_repeats;
      deferred_repeats = '0;
      deferred_presses = '0;
    end
    res.held_mask    = poll.buttons_now;
    res.pressed_mask = fresh;
    res.repeat_mask  = pulses;
    return res;
  endfunction

  task automatic check_result(input bar_out_t got);
    bar_out_t want;
    if (expected_masks.size() == 0) begin
      report_fail($sformatf("result transfer with no poll pending, held %08h",
                            got.held_mask));
      return;
    end
    want = expected_masks.pop_front();
    if (got.held_mask !== want.held_mask)
      report_fail($sformatf("held_mask %08h, expected %08h", got.held_mask,
                            want.held_mask));
    if (got.pressed_mask !== want.pressed_mask)
      report_fail($sformatf("pressed_mask %08h, expected %08h", got.pressed_mask,
                            want.pressed_mask));
    if (got.repeat_mask !== want.repeat_mask)
      report_fail($sformatf("repeat_mask %08h, expected %08h", got.repeat_mask,
                            want.repeat_mask));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_step         = StepReset;
      rep_threshold    = ThresholdReset;
      rep_reload       = ReloadReset;
      last_word        = '0;
      deferred_presses = '0;
      deferred_repeats = '0;
      for (int lane = 0; lane < ButtonWidth; lane++) lane_count[lane] = '0;
      expected_masks.delete();
      outstanding = 0;
    end else begin
      // result first: a result can never leave in the cycle its poll enters
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) expected_masks.push_back(predict_poll(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP:      rep_step      = cfg_wdata_i;
          REG_THRESHOLD: rep_threshold = cfg_wdata_i;
          REG_RELOAD:    rep_reload    = cfg_wdata_i;
          default: ;     // unmapped index, write dropped
        endcase
      end
      outstanding = expected_masks.size();
    end
  end

endmodule

[tb/tb_button_auto_repeat_unit.sv]
// ----------------------------------------------------------------------------
// tb_button_auto_repeat_unit
// Drives polls and register writes into the auto-repeat unit with random
// gaps and output stalls; a checker beside the unit predicts every result.
// Directed polls cover full and empty words, deferral and flush, zero
// threshold and register extremes, then phases of random polls follow.
// ----------------------------------------------------------------------------
module tb_button_auto_repeat_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bar_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 4;
  localparam int MaxGap      = 10;
  localparam int StallLimit  = 2000;
  localparam int PhaseCount  = 14;
  localparam int PhaseLen    = 100;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  bar_in_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bar_out_t               out_data;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx   = '0;
  logic [CfgWidth-1:0]    cfg_wdata = '0;
  int                     fail_count;
  int                     outstanding;

  int                     gap_max     = MaxGap;
  int                     idle_cycles = 0;
  int                     polls_sent  = 0;
  int                     deferred    = 0;
  int                     settings    = 0;
  logic [ButtonWidth-1:0] word        = '0;
  logic                   defer_on    = 1'b0;

  always #HalfPeriod clk = ~clk;

  button_auto_repeat_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  button_repeat_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // watchdog: any transfer resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each transfer, valid stays high across
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // called just after the clock rises; returns when the poll transfer is taken
  task automatic send_poll(input logic [ButtonWidth-1:0] buttons, input logic defer);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{buttons_now: buttons, defer_flag: defer};
    do @(posedge clk); while (!in_ready);
    polls_sent++;
    if (defer) deferred++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set plus a write to the unmapped index, which must be dropped
  task automatic set_regs(input logic [CfgWidth-1:0] step, input logic [CfgWidth-1:0] thr,
                          input logic [CfgWidth-1:0] reload);
    settle();
    write_reg(REG_STEP, step);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RELOAD, reload);
    write_reg(RegUnused, CfgWidth'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // mostly small edits so buttons stay held long enough to hit the threshold
  function automatic logic [ButtonWidth-1:0] next_word(input logic [ButtonWidth-1:0] prev);
    logic [ButtonWidth-1:0] w;
    int                     flips;
    w = prev;
    case ($urandom_range(0, 15))
      0:       w = '0;
      1:       w = '1;
      2, 3:    w = $urandom();
      default: begin
        flips = $urandom_range(0, 3);
        for (int k = 0; k < flips; k++) w[$urandom_range(0, ButtonWidth - 1)] ^= 1'b1;
      end
    endcase
    return w;
  endfunction

  initial begin
    logic [CfgWidth-1:0] step;
    logic [CfgWidth-1:0] thr;
    logic [CfgWidth-1:0] reload;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: presses, hold, release, deferral and flush
    send_poll(32'h0000_0000, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'h8000_0000, 1'b0);
    send_poll(32'h0000_0001, 1'b1);
    send_poll(32'hAAAA_AAAA, 1'b1);
    send_poll(32'h5555_5555, 1'b0);
    send_poll(32'h0000_0000, 1'b0);

    // counters wrap at maximum step while the buttons stay held
    set_regs(8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'h0000_0000, 1'b0);

    // zero threshold: every held button pulses each poll
    set_regs(8'h00, 8'h00, 8'h00);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b1);
    send_poll(32'h0000_FFFF, 1'b1);
    send_poll(32'h0000_0000, 1'b0);

    // step wraps the counter short of the threshold, so only presses pulse; some polls deferred
    set_regs(8'd128, 8'd200, 8'd100);
    send_poll(32'h0000_00FF, 1'b0);
    send_poll(32'h0000_00FF, 1'b1);
    send_poll(32'h0000_00FF, 1'b1);
    send_poll(32'h0000_00FF, 1'b0);
    send_poll(32'h0000_00FF, 1'b0);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 5)
        0: begin
          step   = CfgWidth'($urandom_range(0, 255));
          thr    = CfgWidth'($urandom_range(0, 255));
          reload = CfgWidth'($urandom_range(0, 255));
        end
        1: begin
          step   = CfgWidth'($urandom_range(1, 16));
          thr    = CfgWidth'($urandom_range(32, 255));
          reload = CfgWidth'($urandom_range(0, thr));
        end
        2: begin
          step   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          thr    = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
          reload = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
        3: begin
          step   = CfgWidth'($urandom_range(0, 255));
          thr    = 8'h00;
          reload = CfgWidth'($urandom_range(0, 255));
        end
        default: begin
          step   = CfgWidth'($urandom_range(20, 90));
          thr    = CfgWidth'($urandom_range(100, 255));
          reload = CfgWidth'($urandom_range(0, 255));
        end
      endcase
      set_regs(step, thr, reload);
      gap_max = (p % 3 == 2) ? 0 : MaxGap;
      for (int i = 0; i < PhaseLen; i++) begin
        if ($urandom_range(0, 7) == 0) defer_on = ~defer_on;
        word = next_word(word);
        send_poll(word, defer_on);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("%0d polls (%0d deferred) checked across %0d register settings",
             polls_sent, deferred, settings);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[button_auto_repeat_unit.f]
design/bar_pkg.sv
design/bar_lane.sv
design/bar_merge.sv
design/button_auto_repeat_unit.sv
design/bar_chk.sv
tb/button_repeat_checker.sv
tb/tb_button_auto_repeat_unit.sv
